### rtl/fcl_pkg.sv
`timescale 1ns / 1ps

package fcl_pkg;

   localparam int KEY_WIDTH   = 96;
   localparam int STAMP_WIDTH = 32;
   localparam int ID_WIDTH    = 8;
   localparam int SLOT_WIDTH  = 8;

   localparam logic [ID_WIDTH-1:0] MAX_ID_RESET = 8'd15;

   typedef enum logic [1:0] {
      OUTCOME_HIT  = 2'd0,
      OUTCOME_NEW  = 2'd1,
      OUTCOME_LRU  = 2'd2,
      OUTCOME_NONE = 2'd3
   } outcome_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic decide;
      logic write_use;
      logic write_entry;
   } fcl_cmd_type;

   typedef struct packed {
      logic hit;
      logic rd_last;
      logic place;
   } fcl_status_type;

endpackage

### rtl/fcl_datapath.sv
`timescale 1ns / 1ps

module fcl_datapath
   import fcl_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fcl_cmd_type            cmd,
   output fcl_status_type         status,
   input  logic                   csr_wr_en,
   input  logic [ID_WIDTH-1:0]    csr_wr_data,
   input  logic [31:0]            req_source_address,
   input  logic [31:0]            req_dest_address,
   input  logic [15:0]            req_source_port,
   input  logic [15:0]            req_dest_port,
   output logic [1:0]             rsp_outcome,
   output logic [ID_WIDTH-1:0]    rsp_context_id,
   output logic [SLOT_WIDTH-1:0]  rsp_slot_index
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = IW + 1;

   logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
   logic [ID_WIDTH-1:0]    id_mem  [TABLE_DEPTH];
   logic [STAMP_WIDTH-1:0] use_mem [TABLE_DEPTH];
   logic                   valid_ff [TABLE_DEPTH];

   logic [ID_WIDTH-1:0]    max_ff;
   logic [ID_WIDTH-1:0]    next_id_ff;
   logic [STAMP_WIDTH-1:0] clk_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [CW-1:0]          active_ff;
   logic [CW-1:0]          active_in;
   logic [ID_WIDTH:0]      span;

   logic [IW-1:0]          rd_idx_ff;
   logic                   chk_ff;
   logic [IW-1:0]          chk_idx_ff;
   logic [KEY_WIDTH-1:0]   key_q_ff;
   logic [ID_WIDTH-1:0]    id_q_ff;
   logic [STAMP_WIDTH-1:0] use_q_ff;
   logic                   vld_q_ff;

   logic                   have_free_ff;
   logic [IW-1:0]          free_idx_ff;
   logic                   have_lru_ff;
   logic [IW-1:0]          lru_idx_ff;
   logic [STAMP_WIDTH-1:0] lru_age_ff;
   logic [ID_WIDTH-1:0]    lru_id_ff;

   outcome_type            res_outcome_ff;
   logic [ID_WIDTH-1:0]    res_id_ff;
   logic [IW-1:0]          res_idx_ff;

   logic                   match;
   logic                   can_new;
   logic [STAMP_WIDTH-1:0] age;

   assign span = {1'b0, max_ff} + {{ID_WIDTH{1'b0}}, 1'b1};
   always_comb begin
      if (span > (ID_WIDTH+1)'(TABLE_DEPTH)) begin
         active_in = CW'(TABLE_DEPTH);
      end else begin
         active_in = CW'(span);
      end
   end

   assign match   = chk_ff && vld_q_ff && (key_q_ff == key_ff);
   assign age     = clk_ff - use_q_ff;
   assign can_new = have_free_ff && (next_id_ff < max_ff);

   assign status.hit     = match;
   assign status.rd_last = ({1'b0, rd_idx_ff} == (active_ff - CW'(1)));
   assign status.place   = can_new || have_lru_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= MAX_ID_RESET;
         next_id_ff <= '0;
         clk_ff     <= '0;
         chk_ff     <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (cmd.start) begin
            clk_ff <= clk_ff + STAMP_WIDTH'(1);
         end
         if (cmd.decide && can_new) begin
            next_id_ff <= next_id_ff + ID_WIDTH'(1);
         end
         if (cmd.write_entry) begin
            valid_ff[res_idx_ff] <= 1'b1;
         end
         chk_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         key_mem[res_idx_ff] <= key_ff;
         id_mem[res_idx_ff]  <= res_id_ff;
      end
      if (cmd.write_entry || cmd.write_use) begin
         use_mem[res_idx_ff] <= clk_ff;
      end
      key_q_ff <= key_mem[rd_idx_ff];
      id_q_ff  <= id_mem[rd_idx_ff];
      use_q_ff <= use_mem[rd_idx_ff];
      vld_q_ff <= valid_ff[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff       <= {req_source_address, req_dest_address,
                          req_source_port, req_dest_port};
         active_ff    <= active_in;
         rd_idx_ff    <= '0;
         have_free_ff <= 1'b0;
         have_lru_ff  <= 1'b0;
      end else begin
         if (cmd.issue) begin
            rd_idx_ff <= rd_idx_ff + IW'(1);
         end
         if (chk_ff && !match) begin
            if (vld_q_ff) begin
               if (!have_lru_ff || (age > lru_age_ff)) begin
                  have_lru_ff <= 1'b1;
                  lru_idx_ff  <= chk_idx_ff;
                  lru_age_ff  <= age;
                  lru_id_ff   <= id_q_ff;
               end
            end else if (!have_free_ff) begin
               have_free_ff <= 1'b1;
               free_idx_ff  <= chk_idx_ff;
            end
         end
      end
      chk_idx_ff <= rd_idx_ff;

      if (match) begin
         res_outcome_ff <= OUTCOME_HIT;
         res_id_ff      <= id_q_ff;
         res_idx_ff     <= chk_idx_ff;
      end else if (cmd.decide) begin
         if (can_new) begin
            res_outcome_ff <= OUTCOME_NEW;
            res_id_ff      <= next_id_ff;
            res_idx_ff     <= free_idx_ff;
         end else if (have_lru_ff) begin
            res_outcome_ff <= OUTCOME_LRU;
            res_id_ff      <= lru_id_ff;
            res_idx_ff     <= lru_idx_ff;
         end else begin
            res_outcome_ff <= OUTCOME_NONE;
            res_id_ff      <= '0;
            res_idx_ff     <= '0;
         end
      end
   end

   assign rsp_outcome    = res_outcome_ff;
   assign rsp_context_id = res_id_ff;
   assign rsp_slot_index = SLOT_WIDTH'(res_idx_ff);

   assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |-> (res_outcome_ff == OUTCOME_NEW || res_outcome_ff == OUTCOME_LRU))
      else $error("entry write without a placement");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (next_id_ff >= $past(next_id_ff)))
      else $error("context id counter went backwards");

   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> ({1'b0, rd_idx_ff} < active_ff))
      else $error("scan read beyond active range");

endmodule

### rtl/fcl_control.sv
`timescale 1ns / 1ps

module fcl_control
   import fcl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output fcl_cmd_type    cmd,
   input  fcl_status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DRAIN,
      HIT,
      DECIDE,
      WRITE,
      RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (status.hit) begin
               state_in = HIT;
            end else if (status.rd_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            if (status.hit) begin
               state_in = HIT;
            end else begin
               state_in = DECIDE;
            end
         end
         HIT: state_in = RESP;
         DECIDE: begin
            if (status.place) begin
               state_in = WRITE;
            end else begin
               state_in = RESP;
            end
         end
         WRITE: state_in = RESP;
         RESP: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == IDLE);
         rsp_valid_ff <= (state_in == RESP);
      end
   end

   assign cmd.start       = req_valid && req_ready_ff;
   assign cmd.issue       = (state_ff == SCAN) && !status.hit;
   assign cmd.decide      = (state_ff == DECIDE);
   assign cmd.write_use   = (state_ff == HIT);
   assign cmd.write_entry = (state_ff == WRITE);

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("input and result both open");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready_ff) |=> (state_ff == SCAN))
      else $error("accepted transaction did not start a scan");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == WRITE) |-> ($past(state_ff) == DECIDE))
      else $error("write-back without a decision");

endmodule

### rtl/flow_context_lookup_lru_core.sv
// Lookup: the scan stops at a hit; a miss scans all N slots, then decides and
//   writes back unless no context is placed; N = min(max_context_id + 1, TABLE_DEPTH)
//   slots are read one per cycle through the single read port of the slot memory.
// Throughput: one transaction at a time; the next is accepted only after the last
//   response is taken, so holding rsp_ready low delays it.
// Reset: synchronous; clears valid bits, use clock, id counter and control, max id 15.
`timescale 1ns / 1ps

module flow_context_lookup_lru_core
   import fcl_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_source_address,
   input  logic [31:0]           req_dest_address,
   input  logic [15:0]           req_source_port,
   input  logic [15:0]           req_dest_port,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_outcome,
   output logic [ID_WIDTH-1:0]   rsp_context_id,
   output logic [SLOT_WIDTH-1:0] rsp_slot_index,
   input  logic                  csr_wr_en,
   input  logic [ID_WIDTH-1:0]   csr_wr_data
);

   fcl_cmd_type    cmd;
   fcl_status_type status;

   fcl_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   fcl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_source_address (req_source_address),
      .req_dest_address   (req_dest_address),
      .req_source_port    (req_source_port),
      .req_dest_port      (req_dest_port),
      .rsp_outcome        (rsp_outcome),
      .rsp_context_id     (rsp_context_id),
      .rsp_slot_index     (rsp_slot_index)
   );

endmodule

### tb/flow_context_lookup_lru_core_tb.sv
`timescale 1ns / 1ps

module flow_context_lookup_lru_core_tb;
   import fcl_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER = 200;

   typedef struct packed {
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } flow_key;

   typedef struct packed {
      outcome_type           outcome;
      logic [ID_WIDTH-1:0]   context_id;
      logic [SLOT_WIDTH-1:0] slot_index;
   } flow_context;

   class flow_table_shadow;
      logic [ID_WIDTH-1:0]    max_id;
      bit                     slot_used[TABLE_DEPTH];
      flow_key                slot_flow[TABLE_DEPTH];
      logic [ID_WIDTH-1:0]    slot_ctx[TABLE_DEPTH];
      logic [STAMP_WIDTH-1:0] slot_stamp[TABLE_DEPTH];
      logic [STAMP_WIDTH-1:0] use_clock;
      logic [ID_WIDTH-1:0]    next_id;
      flow_context            pending_contexts[$];

      function new();
         max_id = MAX_ID_RESET;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         use_clock = '0;
         next_id = '0;
      endfunction

      function void set_max_id(logic [ID_WIDTH-1:0] value);
         max_id = value;
      endfunction

      function int pending();
         return pending_contexts.size();
      endfunction

      function void note_lookup(flow_key key);
         int active;
         bit have_free;
         bit have_lru;
         int free_slot;
         int lru_slot;
         int target;
         logic [STAMP_WIDTH-1:0] lru_age;
         logic [STAMP_WIDTH-1:0] age;
         flow_context ctx;
         active = int'(max_id) + 1;
         if (active > TABLE_DEPTH) active = TABLE_DEPTH;
         have_free = 1'b0;
         have_lru = 1'b0;
         free_slot = 0;
         lru_slot = 0;
         lru_age = '0;
         use_clock = use_clock + 1'b1;
         for (int i = 0; i < active; i++) begin
            if (slot_used[i]) begin
               if (slot_flow[i] == key) begin
                  slot_stamp[i] = use_clock;
                  ctx.outcome = OUTCOME_HIT;
                  ctx.context_id = slot_ctx[i];
                  ctx.slot_index = SLOT_WIDTH'(i);
                  pending_contexts.push_back(ctx);
                  return;
               end
               age = use_clock - slot_stamp[i];
               if (!have_lru || age > lru_age) begin
                  have_lru = 1'b1;
                  lru_slot = i;
                  lru_age = age;
               end
            end else if (!have_free) begin
               have_free = 1'b1;
               free_slot = i;
            end
         end
         if (have_free && next_id < max_id) begin
            ctx.outcome = OUTCOME_NEW;
            ctx.context_id = next_id;
            next_id = next_id + 1'b1;
            target = free_slot;
         end else if (have_lru) begin
            ctx.outcome = OUTCOME_LRU;
            ctx.context_id = slot_ctx[lru_slot];
            target = lru_slot;
         end else begin
            ctx.outcome = OUTCOME_NONE;
            ctx.context_id = '0;
            ctx.slot_index = '0;
            pending_contexts.push_back(ctx);
            return;
         end
         slot_used[target] = 1'b1;
         slot_flow[target] = key;
         slot_ctx[target] = ctx.context_id;
         slot_stamp[target] = use_clock;
         ctx.slot_index = SLOT_WIDTH'(target);
         pending_contexts.push_back(ctx);
      endfunction

      function string check_context(flow_context got);
         flow_context want;
         if (pending_contexts.size() == 0)
            return $sformatf("result with nothing pending: outcome %0d id %0d slot %0d",
                             got.outcome, got.context_id, got.slot_index);
         want = pending_contexts.pop_front();
         if (got !== want)
            return $sformatf("outcome %0d/%0d id %0d/%0d slot %0d/%0d (got/expected)",
                             got.outcome, want.outcome, got.context_id, want.context_id,
                             got.slot_index, want.slot_index);
         return "";
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_source_address = '0;
   logic [31:0]           req_dest_address = '0;
   logic [15:0]           req_source_port = '0;
   logic [15:0]           req_dest_port = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_outcome;
   logic [ID_WIDTH-1:0]   rsp_context_id;
   logic [SLOT_WIDTH-1:0] rsp_slot_index;
   logic                  csr_wr_en = 1'b0;
   logic [ID_WIDTH-1:0]   csr_wr_data = '0;

   flow_table_shadow shadow = new();
   flow_key          flow_pool[$];
   int               error_count = 0;
   int               rsp_count = 0;
   int               quiet_cycles = 0;
   bit               steady = 1'b0;

   flow_context_lookup_lru_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_source_address (req_source_address),
      .req_dest_address   (req_dest_address),
      .req_source_port    (req_source_port),
      .req_dest_port      (req_dest_port),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_outcome        (rsp_outcome),
      .rsp_context_id     (rsp_context_id),
      .rsp_slot_index     (rsp_slot_index),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic flow_key random_flow();
      flow_key k;
      k.source_ip = $urandom;
      k.dest_ip = $urandom;
      k.src_port = $urandom_range(0, 65535);
      k.dst_port = $urandom_range(0, 65535);
      return k;
   endfunction

   task automatic send_lookup(flow_key key);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_address <= key.source_ip;
      req_dest_address <= key.dest_ip;
      req_source_port <= key.src_port;
      req_dest_port <= key.dst_port;
      do @(posedge clock); while (!req_ready);
      shadow.note_lookup(key);
   endtask

   task automatic write_max_id(logic [ID_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.set_max_id(value);
   endtask

   task automatic run_phase(logic [ID_WIDTH-1:0] max_id, int count);
      int pool_size;
      int r;
      flow_key k;
      write_max_id(max_id);
      flow_pool.delete();
      pool_size = $urandom_range(3, 24);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (flow_pool.size() == 0 || r < 20) begin
            k = random_flow();
            if (flow_pool.size() < pool_size) flow_pool.push_back(k);
            else flow_pool[$urandom_range(0, flow_pool.size() - 1)] = k;
         end else if (r < 80) begin
            k = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
         end else if (r < 90) begin
            // near miss: one bit off in one field
            k = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            case ($urandom_range(0, 3))
               0: k.source_ip[$urandom_range(0, 31)] ^= 1'b1;
               1: k.dest_ip[$urandom_range(0, 31)] ^= 1'b1;
               2: k.src_port[$urandom_range(0, 15)] ^= 1'b1;
               default: k.dst_port[$urandom_range(0, 15)] ^= 1'b1;
            endcase
         end else begin
            k = random_flow();
         end
         send_lookup(k);
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("flow_context_lookup_lru_core_tb failed");
         $finish;
      end
   end

   initial begin
      int stall;
      bit held;
      flow_context got;
      string msg;
      stall = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.outcome = outcome_type'(rsp_outcome);
            got.context_id = rsp_context_id;
            got.slot_index = rsp_slot_index;
            msg = shadow.check_context(got);
            if (msg != "") report_error(msg);
            rsp_count++;
         end
         // hold off once so that the block backs up into its input
         if (!held && rsp_count >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall == 0 && !steady) stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      flow_key zero_key;
      flow_key ones_key;
      flow_key k;
      zero_key = '0;
      ones_key = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table with no ids to hand out
      write_max_id(8'd0);
      send_lookup(zero_key);
      send_lookup(ones_key);

      write_max_id(MAX_ID_RESET);
      send_lookup(zero_key);
      send_lookup(ones_key);
      send_lookup(zero_key);
      k = '0; k.source_ip = '1; send_lookup(k);
      k = '0; k.dest_ip = '1; send_lookup(k);
      k = '0; k.src_port = '1; send_lookup(k);
      k = '0; k.dst_port = '1; send_lookup(k);
      for (int n = 0; n < 9; n++) send_lookup(random_flow());
      // free slot left but ids used up
      send_lookup(random_flow());
      send_lookup(ones_key);
      send_lookup(random_flow());

      run_phase(8'd1, 70);
      run_phase(8'd255, 80);
      steady = 1'b1;
      run_phase(8'd3, 70);
      steady = 1'b0;
      run_phase(8'd8, 80);
      run_phase(8'd0, 40);
      run_phase(ID_WIDTH'($urandom_range(2, 254)), 80);
      run_phase(8'd255, 80);
      run_phase(8'd2, 60);
      run_phase(MAX_ID_RESET, 70);

      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("flow_context_lookup_lru_core_tb passed");
      else
         $display("flow_context_lookup_lru_core_tb failed");
      $finish;
   end

endmodule
